// ----- hdl/owrs_pkg.sv -----
package owrs_pkg;

   // Fixed field widths
   localparam int CODE_BITS   = 64;
   localparam int POS_W       = 7;
   localparam int CNT_W       = 4;
   localparam int SLOT_W      = 3;
   localparam int CMD_W       = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   // Defaults
   localparam int DEF_MAX_DEVICES        = 8;
   localparam logic [7:0] RST_SEARCH_CMD = 8'd240;
   localparam logic [3:0] RST_MAX_DEV    = 4'd8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_CMD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEV    = 1'b1;

   // Request operations
   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_PRESENCE = 2'd1,
      OP_BIT_PAIR = 2'd2,
      OP_READ     = 2'd3
   } op_type;

   // Response actions
   typedef enum logic [2:0] {
      ACT_RESET = 3'd0,
      ACT_CMD   = 3'd1,
      ACT_BIT   = 3'd2,
      ACT_FOUND = 3'd3,
      ACT_DONE  = 3'd4,
      ACT_ENTRY = 3'd5
   } action_type;

endpackage

// ----- hdl/one_wire_rom_search_top.sv -----
// Channel   Ports                                         Handshake
// request   req_operation/presence/bit_true/               start && !busy
//           bit_complement/entry_index
// response  rsp_action/tx_byte/tx_bit/rom_code/            rsp_strobe, one cycle
//           device_index/device_count/last_of_run
// csr       csr_we, csr_index, csr_wdata                   csr_we, no wait
//
// An item that fits the phase gives its first response in the cycle after
// it is taken. The 64th bit pair gives three responses (bit, found, then
// reset or done), with busy high while the last two are pending, set by the
// single response port. A read returns the table entry via the memory read port.
// Reset is synchronous and clears control state and the table valid bits, so
// the table reads zero at once; no clearing pass. The receiver cannot stall.
module one_wire_rom_search_top #(
   parameter int MAX_DEVICES = owrs_pkg::DEF_MAX_DEVICES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic                              req_presence,
   input  logic                              req_bit_true,
   input  logic                              req_bit_complement,
   input  logic [owrs_pkg::SLOT_W-1:0]       req_entry_index,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_action,
   output logic [owrs_pkg::CMD_W-1:0]        rsp_tx_byte,
   output logic                              rsp_tx_bit,
   output logic [owrs_pkg::CODE_BITS-1:0]    rsp_rom_code,
   output logic [owrs_pkg::SLOT_W-1:0]       rsp_device_index,
   output logic [owrs_pkg::CNT_W-1:0]        rsp_device_count,
   output logic                              rsp_last_of_run,
   input  logic                              csr_we,
   input  logic [owrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [owrs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import owrs_pkg::*;

   localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_BITS);
   localparam logic [POS_W-1:0] MAX_DEV7 = POS_W'(MAX_DEVICES);

   typedef enum logic [1:0] {PH_IDLE, PH_PRES, PH_BITS} phase_type;
   typedef enum logic [1:0] {SQ_RUN, SQ_FOUND, SQ_TAIL} seq_type;

   // Control and search state
   phase_type                  phase_ff, phase_in;
   seq_type                    seq_ff, seq_in;
   logic [CMD_W-1:0]           cmd_ff, cmd_in;
   logic [CNT_W-1:0]           maxdev_ff, maxdev_in;
   logic [CNT_W-1:0]           found_ff, found_in;
   logic [POS_W-1:0]           ld_ff, ld_in;
   logic [POS_W-1:0]           pd_ff, pd_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [CODE_BITS-1:0]       acc_ff, acc_in;
   logic [MAX_DEVICES-1:0]     vld_ff, vld_in;
   logic                       tail_done_ff, tail_done_in;
   logic                       rd_vld_ff, rd_vld_in;

   // Response registers
   logic                       rsp_strobe_ff, rsp_strobe_in;
   action_type                 rsp_action_ff, rsp_action_in;
   logic [CMD_W-1:0]           rsp_tx_byte_ff, rsp_tx_byte_in;
   logic                       rsp_tx_bit_ff, rsp_tx_bit_in;
   logic [CODE_BITS-1:0]       rsp_code_ff, rsp_code_in;
   logic                       rsp_from_mem_ff, rsp_from_mem_in;
   logic [SLOT_W-1:0]          rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Code table memory
   logic [CODE_BITS-1:0]       mem [MAX_DEVICES];
   logic [CODE_BITS-1:0]       mem_q;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   logic [IDX_W-1:0]           mem_raddr;

   // Decode helpers
   logic                       accept;
   logic [POS_W-1:0]           limit;
   logic [POS_W-1:0]           entry7;
   logic [POS_W-1:0]           slot7;
   logic [POS_W-1:0]           found_next7;
   logic [5:0]                 bit_sel;
   logic                       chosen;

   assign accept      = start && !busy;
   assign busy        = (seq_ff != SQ_RUN);
   assign limit       = (POS_W'(maxdev_ff) < MAX_DEV7) ? POS_W'(maxdev_ff) : MAX_DEV7;
   assign entry7      = POS_W'(req_entry_index);
   assign slot7       = POS_W'(found_ff);
   assign found_next7 = POS_W'(found_ff) + POS_W'(1);
   assign bit_sel     = 6'(pos_ff - POS_W'(1));
   assign mem_raddr   = entry7[IDX_W-1:0];
   assign mem_waddr   = slot7[IDX_W-1:0];

   // Conflict resolution; bits at and above the current position in the
   // accumulator still hold the previous device's code
   always_comb begin
      if (pos_ff < ld_ff) begin
         chosen = acc_ff[bit_sel];
      end else begin
         chosen = (pos_ff == ld_ff);
      end
      if (req_bit_true || req_bit_complement) begin
         chosen = req_bit_true;
      end
   end

   // Next-state logic
   always_comb begin
      phase_in        = phase_ff;
      seq_in          = seq_ff;
      cmd_in          = cmd_ff;
      maxdev_in       = maxdev_ff;
      found_in        = found_ff;
      ld_in           = ld_ff;
      pd_in           = pd_ff;
      pos_in          = pos_ff;
      acc_in          = acc_ff;
      vld_in          = vld_ff;
      tail_done_in    = tail_done_ff;
      rd_vld_in       = rd_vld_ff;
      mem_we          = 1'b0;
      rsp_strobe_in   = 1'b0;
      rsp_action_in   = ACT_RESET;
      rsp_tx_byte_in  = '0;
      rsp_tx_bit_in   = 1'b0;
      rsp_code_in     = '0;
      rsp_from_mem_in = 1'b0;
      rsp_index_in    = '0;
      rsp_count_in    = '0;
      rsp_last_in     = 1'b1;

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_SEARCH_CMD: cmd_in    = csr_wdata;
            CSR_MAX_DEV:    maxdev_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      unique case (seq_ff)
         SQ_FOUND: begin
            rsp_strobe_in = 1'b1;
            rsp_action_in = ACT_FOUND;
            rsp_code_in   = acc_ff;
            rsp_index_in  = SLOT_W'(found_ff - CNT_W'(1));
            rsp_count_in  = found_ff;
            rsp_last_in   = 1'b0;
            seq_in        = SQ_TAIL;
         end
         SQ_TAIL: begin
            rsp_strobe_in = 1'b1;
            rsp_action_in = tail_done_ff ? ACT_DONE : ACT_RESET;
            rsp_count_in  = tail_done_ff ? found_ff : '0;
            seq_in        = SQ_RUN;
         end
         default: begin
            if (accept) begin
               unique case (op_type'(req_operation))
                  OP_START: begin
                     vld_in        = '0;
                     found_in      = '0;
                     ld_in         = '0;
                     pd_in         = '0;
                     pos_in        = POS_W'(1);
                     acc_in        = '0;
                     rsp_strobe_in = 1'b1;
                     if (limit == '0) begin
                        phase_in      = PH_IDLE;
                        rsp_action_in = ACT_DONE;
                     end else begin
                        phase_in      = PH_PRES;
                        rsp_action_in = ACT_RESET;
                     end
                  end
                  OP_PRESENCE: begin
                     if (phase_ff == PH_PRES) begin
                        rsp_strobe_in = 1'b1;
                        if (!req_presence) begin
                           phase_in      = PH_IDLE;
                           rsp_action_in = ACT_DONE;
                           rsp_count_in  = found_ff;
                        end else begin
                           phase_in       = PH_BITS;
                           pd_in          = '0;
                           pos_in         = POS_W'(1);
                           rsp_action_in  = ACT_CMD;
                           rsp_tx_byte_in = cmd_ff;
                        end
                     end
                  end
                  OP_BIT_PAIR: begin
                     if (phase_ff == PH_BITS) begin
                        rsp_strobe_in = 1'b1;
                        if (req_bit_true && req_bit_complement) begin
                           phase_in      = PH_IDLE;
                           rsp_action_in = ACT_DONE;
                           rsp_count_in  = found_ff;
                        end else begin
                           if (!req_bit_true && !req_bit_complement && !chosen) begin
                              pd_in = pos_ff;
                           end
                           acc_in[bit_sel] = chosen;
                           rsp_action_in   = ACT_BIT;
                           rsp_tx_bit_in   = chosen;
                           if (pos_ff == LAST_POS) begin
                              // Store the code while the table has room and queue found plus reset/done
                              mem_we      = (slot7 < MAX_DEV7);
                              for (int i = 0; i < MAX_DEVICES; i++) begin
                                 if (mem_we && mem_waddr == IDX_W'(i)) begin
                                    vld_in[i] = 1'b1;
                                 end
                              end
                              found_in     = found_ff + CNT_W'(1);
                              ld_in        = pd_in;
                              pos_in       = POS_W'(1);
                              tail_done_in = (pd_in == '0) || (found_next7 >= limit);
                              phase_in     = tail_done_in ? PH_IDLE : PH_PRES;
                              seq_in       = SQ_FOUND;
                              rsp_last_in  = 1'b0;
                           end else begin
                              pos_in = pos_ff + POS_W'(1);
                           end
                        end
                     end
                  end
                  default: begin
                     // Table read; data arrives from the memory next cycle
                     rd_vld_in = 1'b0;
                     for (int i = 0; i < MAX_DEVICES; i++) begin
                        if (entry7 < MAX_DEV7 && mem_raddr == IDX_W'(i) && vld_ff[i]) begin
                           rd_vld_in = 1'b1;
                        end
                     end
                     rsp_strobe_in   = 1'b1;
                     rsp_action_in   = ACT_ENTRY;
                     rsp_from_mem_in = 1'b1;
                     rsp_index_in    = req_entry_index;
                     rsp_count_in    = found_ff;
                  end
               endcase
            end
         end
      endcase
   end

   // State and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         seq_ff          <= SQ_RUN;
         cmd_ff          <= RST_SEARCH_CMD;
         maxdev_ff       <= RST_MAX_DEV;
         found_ff        <= '0;
         ld_ff           <= '0;
         pd_ff           <= '0;
         pos_ff          <= POS_W'(1);
         acc_ff          <= '0;
         vld_ff          <= '0;
         tail_done_ff    <= 1'b0;
         rd_vld_ff       <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         rsp_from_mem_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         seq_ff          <= seq_in;
         cmd_ff          <= cmd_in;
         maxdev_ff       <= maxdev_in;
         found_ff        <= found_in;
         ld_ff           <= ld_in;
         pd_ff           <= pd_in;
         pos_ff          <= pos_in;
         acc_ff          <= acc_in;
         vld_ff          <= vld_in;
         tail_done_ff    <= tail_done_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         rsp_from_mem_ff <= rsp_from_mem_in;
      end
      rsp_action_ff  <= rsp_action_in;
      rsp_tx_byte_ff <= rsp_tx_byte_in;
      rsp_tx_bit_ff  <= rsp_tx_bit_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Code table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= acc_in;
      end
      mem_q <= mem[mem_raddr];
   end

   // Response ports
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_tx_byte      = rsp_tx_byte_ff;
   assign rsp_tx_bit       = rsp_tx_bit_ff;
   assign rsp_rom_code     = rsp_from_mem_ff ? (rd_vld_ff ? mem_q : '0) : rsp_code_ff;
   assign rsp_device_index = rsp_index_ff;
   assign rsp_device_count = rsp_count_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   // Checks
   a_found_follows: assert property (@(posedge clock) disable iff (reset)
      seq_ff == SQ_FOUND |=> rsp_strobe && rsp_action == ACT_FOUND)
      else $error("found response missing after last bit");

   a_found_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_action == ACT_FOUND |=> rsp_strobe && rsp_last_of_run)
      else $error("found response not followed by closing response");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff >= POS_W'(1) && pos_ff <= LAST_POS)
      else $error("bit position out of range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      POS_W'(found_ff) <= MAX_DEV7)
      else $error("device count beyond table depth");

   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("busy cycle without pending response");

endmodule
